// ----- src/substring_match_counter_top_macros.svh -----
// Assertion macros for the substring match counter RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef SUBSTRING_MATCH_COUNTER_TOP_MACROS_SVH
`define SUBSTRING_MATCH_COUNTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SMC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smc check failed");

// Next-cycle implication, disabled while reset is high.
`define SMC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smc check failed");

`endif

// ----- src/smc_pkg.sv -----
// Shared types and constants for the substring match counter.
// No dependencies; imported by every module of the block.
package smc_pkg;

  localparam int MAX_PATTERN_DEF   = 16;
  localparam int POSITION_BITS_DEF = 16;
  localparam int COUNT_W           = 16;
  localparam int CFG_W             = 64;
  localparam int PLEN_W            = 5;
  localparam int CFG_IDX_W         = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LOW  = 2'd0,
    REG_PAT_HIGH = 2'd1,
    REG_PAT_LEN  = 2'd2
  } cfg_reg_t;

  // One processed byte, window stage to tracker.
  typedef struct packed {
    logic fire;
    logic last;
    logic hit;
  } step_t;

  // Result of one text.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] first;
    logic               found;
    logic               too_long;
  } res_t;

endpackage

// ----- src/smc_cfg.sv -----
// Configuration registers plus pre-aligned pattern and care mask.
// Depends on smc_pkg.
module smc_cfg import smc_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int LEN_BITS    = $clog2(MAX_PATTERN + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  output logic [MAX_PATTERN-1:0][7:0] aligned,
  output logic [MAX_PATTERN-1:0]      care,
  output logic [LEN_BITS-1:0]         len
);

  logic [CFG_W-1:0]  pat_low;
  logic [CFG_W-1:0]  pat_high;
  logic [PLEN_W-1:0] pat_len;

  logic [2*CFG_W-1:0]              pat_all;
  logic [MAX_PATTERN-1:0][7:0]     pat;
  logic [MAX_PATTERN-1:0][7:0]     rev;
  logic [MAX_PATTERN-1:0][7:0]     aligned_next;
  logic [MAX_PATTERN-1:0]          care_next;
  logic [LEN_BITS-1:0]             len_next;
  logic [LEN_BITS-1:0]             shift_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_low  <= '0;
      pat_high <= '0;
      pat_len  <= PLEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PAT_LOW:  pat_low  <= cfg_data;
        REG_PAT_HIGH: pat_high <= cfg_data;
        REG_PAT_LEN:  pat_len  <= cfg_data[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp length to 1..MAX_PATTERN.
  always_comb begin
    if (pat_len == '0) begin
      len_next = LEN_BITS'(1);
    end else if (pat_len > PLEN_W'(MAX_PATTERN)) begin
      len_next = LEN_BITS'(MAX_PATTERN);
    end else begin
      len_next = LEN_BITS'(pat_len);
    end
  end

  assign pat_all     = {pat_high, pat_low};
  assign pat         = pat_all[MAX_PATTERN*8-1:0];
  assign shift_bytes = LEN_BITS'(MAX_PATTERN) - len_next;

  // aligned[k] = pattern byte (len-1-k): the byte that window entry k must hold.
  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      rev[MAX_PATTERN-1-j] = pat[j];
    end
    aligned_next = rev >> {shift_bytes, 3'b000};
    for (int k = 0; k < MAX_PATTERN; k++) begin
      care_next[k] = (k < int'(len_next));
    end
  end

  always_ff @(posedge clk) begin
    aligned <= aligned_next;
    care    <= care_next;
    len     <= len_next;
  end

endmodule

// ----- src/smc_window.sv -----
// Byte window shift register and parallel pattern compare.
// Depends on smc_pkg.
module smc_window import smc_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic                        clk,
  input  logic                        shift_en,
  input  logic [7:0]                  byte_in,
  input  logic [MAX_PATTERN-1:0][7:0] aligned,
  input  logic [MAX_PATTERN-1:0]      care,
  output logic                        hit
);

  logic [MAX_PATTERN-1:0][7:0] win;
  logic [MAX_PATTERN-1:0][7:0] win_next;
  logic [MAX_PATTERN-1:0]      ok;

  // Entry 0 is the newest byte.
  always_comb begin
    win_next[0] = byte_in;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_next[k] = win[k-1];
    end
    for (int k = 0; k < MAX_PATTERN; k++) begin
      ok[k] = !care[k] || (win_next[k] == aligned[k]);
    end
  end

  assign hit = &ok;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      win <= win_next;
    end
  end

endmodule

// ----- src/smc_track.sv -----
// Per-text position, match count and first-match bookkeeping.
// Depends on smc_pkg.
module smc_track import smc_pkg::*; #(
  parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int LEN_BITS      = $clog2(MAX_PATTERN + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  step_t               step,
  input  logic [LEN_BITS-1:0] len,
  output res_t                res
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  logic [POSITION_BITS-1:0] pos;
  logic [POSITION_BITS-1:0] nas;
  logic [COUNT_W-1:0]       count;
  logic [POSITION_BITS-1:0] first;
  logic                     any;

  logic [POSITION_BITS-1:0] p1, len_pb, start, text_len;
  logic                     sat, can;
  logic [POSITION_BITS-1:0] pos_next, nas_next, first_next;
  logic [COUNT_W-1:0]       count_next;
  logic                     any_next;

  always_comb begin
    sat      = (pos == POS_MAX);
    p1       = pos + 1'b1;
    len_pb   = POSITION_BITS'(len);
    start    = p1 - len_pb;
    can      = !sat && (p1 >= len_pb) && (start >= nas) && step.hit;
    count_next = (can && (count != '1)) ? count + 1'b1 : count;
    first_next = (can && !any) ? start : first;
    any_next   = any || can;
    nas_next   = can ? p1 : nas;
    pos_next   = sat ? pos : p1;
    text_len   = sat ? pos : p1;

    res.count    = count_next;
    res.first    = COUNT_W'(first_next);
    res.found    = any_next;
    res.too_long = (len_pb > text_len);
  end

  always_ff @(posedge clk) begin
    if (rst || (step.fire && step.last)) begin
      pos   <= '0;
      nas   <= '0;
      count <= '0;
      first <= '0;
      any   <= 1'b0;
    end else if (step.fire) begin
      pos   <= pos_next;
      nas   <= nas_next;
      count <= count_next;
      first <= first_next;
      any   <= any_next;
    end
  end

endmodule

// ----- src/substring_match_counter_top.sv -----
// Top level of the substring match counter: ports, input and result registers.
// Depends on smc_pkg, smc_cfg, smc_window, smc_track and the macros header.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------
//  in      | in_valid / in_stall   | text_byte, is_last
//  out     | out_valid / out_stall | match_total, first_index, found,
//          |                       |   pattern_too_long
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One text byte per cycle while in_stall is low. A beat is registered on accept
// and processed when it leaves the input register, where the window compare and
// the tracker update happen; the last byte of a text loads the result register
// at that edge, so a result passes the input and result registers in turn.
// in_stall rises only when a last beat waits in the input register while the
// result register still holds an untaken result; non-last beats never stall.
// cfg_ready is always high; synchronous reset rst clears all control state.
`include "substring_match_counter_top_macros.svh"

module substring_match_counter_top import smc_pkg::*; #(
  parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           text_byte,
  input  logic                 is_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [COUNT_W-1:0]   match_total,
  output logic [COUNT_W-1:0]   first_index,
  output logic                 found,
  output logic                 pattern_too_long,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int LEN_BITS = $clog2(MAX_PATTERN + 1);

  // input register
  logic       r_valid;
  logic [7:0] r_byte;
  logic       r_last;

  logic out_free;   // result register can take a new result this cycle
  logic fire;       // input register beat is processed this edge
  logic accept;

  logic [MAX_PATTERN-1:0][7:0] aligned;
  logic [MAX_PATTERN-1:0]      care;
  logic [LEN_BITS-1:0]         len;
  logic                        hit;
  step_t                       step;
  res_t                        res;
  res_t                        res_q;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = r_valid && r_last && !out_free;
  assign fire      = r_valid && !in_stall;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (accept) begin
      r_valid <= 1'b1;
    end else if (fire) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_byte <= text_byte;
      r_last <= is_last;
    end
  end

  smc_cfg #(
    .MAX_PATTERN (MAX_PATTERN),
    .LEN_BITS    (LEN_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .aligned   (aligned),
    .care      (care),
    .len       (len)
  );

  smc_window #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_window (
    .clk      (clk),
    .shift_en (fire),
    .byte_in  (r_byte),
    .aligned  (aligned),
    .care     (care),
    .hit      (hit)
  );

  assign step.fire = fire;
  assign step.last = r_last;
  assign step.hit  = hit;

  smc_track #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS),
    .LEN_BITS      (LEN_BITS)
  ) u_track (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .len  (len),
    .res  (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && r_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && r_last) begin
      res_q <= res;
    end
  end

  assign match_total      = res_q.count;
  assign first_index      = res_q.first;
  assign found            = res_q.found;
  assign pattern_too_long = res_q.too_long;

  `SMC_ASSERT_NXT(a_last_loads_result, clk, rst, fire && r_last, out_valid)
  `SMC_ASSERT_IMP(a_found_iff_count, clk, rst, out_valid, found == (match_total != '0))
  `SMC_ASSERT_IMP(a_no_find_no_index, clk, rst, out_valid && !found, first_index == '0)

endmodule

// ----- bench/substring_match_counter_top_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for substring_match_counter_top: counting of non-overlapping matches.
// Needs smc_pkg and the RTL only. A local byte-level model predicts each text's result.

module substring_match_counter_top_tb;
  import smc_pkg::*;

  localparam int POS_MAX      = 65535;  // position and text length saturate here
  localparam int CNT_MAX      = 65535;
  localparam int DRAIN_CYCLES = 6;      // margin for the input and result registers to empty
  localparam int RANDOM_BEATS = 1550;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_beat_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [7:0]           text_byte = '0;
  logic                 is_last   = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [COUNT_W-1:0]   match_total;
  logic [COUNT_W-1:0]   first_index;
  logic                 found;
  logic                 pattern_too_long;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  substring_match_counter_top u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .text_byte        (text_byte),
    .is_last          (is_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .match_total      (match_total),
    .first_index      (first_index),
    .found            (found),
    .pattern_too_long (pattern_too_long),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // Beats waiting to be driven, and per-text results the model has predicted.
  text_beat_t text_beats[$];
  res_t       expected_results[$];
  int         beats_queued = 0;
  int         errors       = 0;

  // Handshake bookkeeping for the rising-edge and falling-edge blocks.
  bit in_taken   = 1'b0;
  bit idle_on    = 1'b1;
  int send_gap   = 0;
  int stall_left = 0;

  // Pattern registers as the model sees them, updated at the write edge.
  logic [63:0] model_lo  = '0;
  logic [63:0] model_hi  = '0;
  logic [4:0]  model_len = 5'd1;
  // Same registers as the stimulus last wrote them, used to build matching text.
  logic [63:0] stim_lo   = '0;
  logic [63:0] stim_hi   = '0;
  logic [4:0]  stim_len  = 5'd1;

  // Per-text search state. win[0] is the newest byte.
  logic [7:0] win [16];
  int         pos;
  int         next_start;
  int         first_pos;
  int         hits;
  bit         any_hit;

  // Length 0 behaves as 1, anything above 16 as 16.
  function automatic int eff_len(input logic [4:0] l);
    if (l == 5'd0) return 1;
    if (l > 5'd16) return 16;
    return int'(l);
  endfunction

  function automatic logic [7:0] pat_byte(input logic [63:0] lo, input logic [63:0] hi,
                                          input int j);
    return (j < 8) ? lo[j*8 +: 8] : hi[(j-8)*8 +: 8];
  endfunction

  function automatic void clear_text();
    foreach (win[i]) win[i] = 8'h00;
    pos        = 0;
    next_start = 0;
    first_pos  = 0;
    hits       = 0;
    any_hit    = 1'b0;
  endfunction

  // Advance the search by one byte; returns 1 with the text's result on the last byte.
  function automatic bit track_byte(input logic [7:0] b, input logic last, output res_t r);
    int len;
    int start;
    int text_len;
    bit sat;
    bit hit;
    len = eff_len(model_len);
    for (int i = 15; i > 0; i--) win[i] = win[i-1];
    win[0] = b;
    sat = (pos >= POS_MAX);
    // Only windows that lie wholly inside the text, starting past the last match.
    if (!sat && pos + 1 >= len) begin
      start = pos + 1 - len;
      hit = (start >= next_start);
      for (int j = 0; j < len; j++)
        if (win[len-1-j] != pat_byte(model_lo, model_hi, j)) hit = 1'b0;
      if (hit) begin
        if (hits < CNT_MAX) hits++;
        if (!any_hit) begin
          first_pos = start;
          any_hit   = 1'b1;
        end
        next_start = pos + 1;
      end
    end
    text_len = sat ? POS_MAX : pos + 1;
    if (!sat) pos++;
    r = '0;
    if (!last) return 1'b0;
    r.count    = hits[COUNT_W-1:0];
    r.first    = first_pos[COUNT_W-1:0];
    r.found    = any_hit;
    r.too_long = (len > text_len);
    clear_text();
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Rising edge: register writes into the model, input beats into the
  // predictor, result beats against the oldest prediction.
  always @(posedge clk) begin : accept_edge
    res_t want;
    res_t got;
    in_taken = 1'b0;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PAT_LOW:  model_lo  = cfg_data;
          REG_PAT_HIGH: model_hi  = cfg_data;
          REG_PAT_LEN:  model_len = cfg_data[PLEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        if (track_byte(text_byte, is_last, want)) expected_results.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got.count    = match_total;
        got.first    = first_index;
        got.found    = found;
        got.too_long = pattern_too_long;
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result: count %0d first %0d found %0b too_long %0b",
                   $time, got.count, got.first, got.found, got.too_long);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("match_total", want.count, got.count);
          check_field("first_index", want.first, got.first);
          check_field("found", 16'(want.found), 16'(got.found));
          check_field("pattern_too_long", 16'(want.too_long), 16'(got.too_long));
        end
      end
    end
  end

  // Sender: a held beat never changes; after a taken beat either idle for a
  // burst or present the next queued beat.
  always @(negedge clk) begin : text_driver
    text_beat_t beat;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(1, 11) - 1;
        in_valid <= 1'b0;
      end else if (text_beats.size() > 0) begin
        beat = text_beats.pop_front();
        text_byte <= beat.data;
        is_last   <= beat.last;
        in_valid  <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall in bursts while idling is enabled.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 11) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic void push_beat(input logic [7:0] d, input logic l);
    text_beat_t beat;
    beat.data = d;
    beat.last = l;
    text_beats.push_back(beat);
    beats_queued++;
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_PAT_LOW:  stim_lo  = value;
      REG_PAT_HIGH: stim_hi  = value;
      REG_PAT_LEN:  stim_len = value[PLEN_W-1:0];
      default: ;
    endcase
  endtask

  // Block is idle once nothing is queued or held and every result is in;
  // non-last beats leave no trace, so let the pipeline drain before going on.
  task automatic wait_drained();
    while (text_beats.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Mostly 'a'/'b' so texts hit the pattern often; some fully random bytes.
  function automatic logic [63:0] rand_pattern_word();
    logic [63:0] w;
    for (int k = 0; k < 8; k++)
      w[k*8 +: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                  : ($urandom_range(0, 1) ? 8'h61 : 8'h62);
    return w;
  endfunction

  function automatic logic [4:0] pick_length();
    case ($urandom_range(0, 7))
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd16;
      3: return 5'($urandom_range(17, 31));
      default: return 5'($urandom_range(2, 15));
    endcase
  endfunction

  // Shaped text splices whole pattern copies into filler mostly of pattern bytes;
  // unshaped text is plain noise. close puts the last flag on the final byte.
  task automatic add_text(input int n, input bit close, input bit shaped);
    int len;
    int i;
    logic [7:0] b;
    len = eff_len(stim_len);
    i = 0;
    while (i < n) begin
      if (shaped && $urandom_range(0, 3) == 0 && i + len <= n) begin
        for (int j = 0; j < len; j++)
          push_beat(pat_byte(stim_lo, stim_hi, j), close && (i + j == n - 1));
        i += len;
      end else begin
        if (shaped && $urandom_range(0, 3) != 0)
          b = pat_byte(stim_lo, stim_hi, $urandom_range(0, len - 1));
        else
          b = 8'($urandom);
        push_beat(b, close && (i == n - 1));
        i++;
      end
    end
  endtask

  initial begin : stimulus
    int r;
    int n;
    clear_text();
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Reset pattern is a single zero byte.
    push_beat(8'h00, 1'b0);
    push_beat(8'hFF, 1'b1);
    wait_drained();

    // "aba" over "abababa": the match at 2 overlaps the one at 0 and is
    // skipped, the one at 4 counts. Then a text shorter than the pattern.
    write_reg(REG_PAT_LOW, 64'h0000_0000_0061_6261);
    write_reg(REG_PAT_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_PAT_LEN, 64'd3);
    for (int k = 0; k < 7; k++) push_beat((k % 2) ? 8'h62 : 8'h61, k == 6);
    push_beat(8'h61, 1'b0);
    push_beat(8'h62, 1'b1);
    wait_drained();

    // Full 16-byte pattern of 00/FF bytes matched by a text of exactly its size.
    write_reg(REG_PAT_LOW, 64'h00FF_00FF_00FF_00FF);
    write_reg(REG_PAT_HIGH, 64'hFF00_FF00_FF00_FF00);
    write_reg(REG_PAT_LEN, 64'd16);
    for (int j = 0; j < 16; j++) push_beat(pat_byte(stim_lo, stim_hi, j), j == 15);
    wait_drained();

    // Length 0 acts as 1: every byte of a zero text is a match of its own.
    write_reg(REG_PAT_LOW, 64'h0);
    write_reg(REG_PAT_HIGH, 64'h0);
    write_reg(REG_PAT_LEN, 64'd0);
    idle_on = 1'b0;
    for (int k = 0; k < 40; k++) push_beat(8'h00, k == 39);
    wait_drained();

    // Random settings, each followed by a burst of texts. Some phases leave
    // a text open so the next register update lands mid-text; the final
    // fifth runs with neither side idling.
    beats_queued = 0;
    while (beats_queued < RANDOM_BEATS) begin
      if (beats_queued > RANDOM_BEATS * 4 / 5) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 4) != 0);
      write_reg(REG_PAT_LOW, rand_pattern_word());
      write_reg(REG_PAT_HIGH, rand_pattern_word());
      write_reg(REG_PAT_LEN, 64'(pick_length()));
      repeat ($urandom_range(3, 12)) begin
        r = $urandom_range(0, 9);
        if (r == 0) n = $urandom_range(1, eff_len(stim_len));
        else if (r < 8) n = $urandom_range(1, 24);
        else n = $urandom_range(25, 70);
        add_text(n, 1'b1, $urandom_range(0, 7) != 0);
      end
      if (beats_queued < RANDOM_BEATS * 4 / 5 && $urandom_range(0, 2) == 0)
        add_text($urandom_range(1, 10), 1'b0, 1'b1);
      wait_drained();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: end the run with a mismatch if the stimulus never finishes.
  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
